// ===== rtl/core/lzrp_pkg.sv =====
// ----------------------------------------------------------------------------
// lzrp_pkg
// Types and constants shared by the RefPack decompressor modules.
// ----------------------------------------------------------------------------
`default_nettype none
package lzrp_pkg;
	localparam logic [7:0] SigByte = 8'hFB;

	// decode phases, one-hot
	typedef enum logic [11:0] {
		PH_FLAGS    = 12'b000000000001,
		PH_SIG      = 12'b000000000010,
		PH_CSIZE    = 12'b000000000100,
		PH_DSIZE    = 12'b000000001000,
		PH_CMD      = 12'b000000010000,
		PH_ARGS     = 12'b000000100000,
		PH_LIT      = 12'b000001000000,
		PH_LIT_STOP = 12'b000010000000,
		PH_COPY     = 12'b000100000000,
		PH_COPY_LAST= 12'b001000000000,
		PH_DONE     = 12'b010000000000,
		PH_ERR      = 12'b100000000000
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_of_block;
		logic       end_of_input;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       byte_taken;
		logic       block_done;
		logic       status;
	} out_item_t;

	// request handed from the front to the back: one window operation
	typedef struct packed {
		logic        wr;        // write a byte to the window
		logic        rd;        // byte comes from the window
		logic        zero;      // reference before output start
		logic [17:0] ref_dist;
		logic [7:0]  lit;
		logic        taken;
		logic        done;
		logic        status;
		logic        clr;       // block start: write pointer to zero
	} req_t;
endpackage
`default_nettype wire

// ===== rtl/core/lzrp_stream_if.sv =====
// ----------------------------------------------------------------------------
// lzrp_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface lzrp_stream_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lz_refpack_decompressor_unit.sv =====
// ----------------------------------------------------------------------------
// lz_refpack_decompressor_unit
// RefPack (QFS) LZ77 decompressor, one compressed byte request per item.
// ----------------------------------------------------------------------------
// channel   dir   payload
// in_ch     sink  in_byte, start_of_block, end_of_input
// out_ch    src   out_valid, out_byte, byte_taken, block_done, status
//
// One item per cycle while the output queue has room; a result is held in
// stage 1, where the registered window RAM read resolves its byte, then in
// the output queue. Reset clears all control state; window contents are
// undefined. A stalled output holds up to three results, then refuses input.
// ----------------------------------------------------------------------------
`default_nettype none
module lz_refpack_decompressor_unit #(
	parameter int WINDOW_DEPTH = 131072
) (
	input wire logic clk,
	input wire logic arst_n,
	lzrp_stream_if.sink   in_ch,
	lzrp_stream_if.source out_ch
);
	import lzrp_pkg::*;

	logic      req_valid, req_ready;
	req_t      req;
	in_item_t  in_item;
	out_item_t out_item;

	assign in_item = in_ch.data;
	assign out_ch.data = out_item;

	lzrp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_item(in_item), .req_valid(req_valid), .req_ready(req_ready), .req(req)
	);

	lzrp_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_item(out_item)
	);
endmodule
`default_nettype wire

// ===== rtl/core/lzrp_ram.sv =====
// ----------------------------------------------------------------------------
// lzrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lzrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 131072
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/lzrp_front.sv =====
// ----------------------------------------------------------------------------
// lzrp_front
// Header and command parser; issues one window request per item.
// ----------------------------------------------------------------------------
`default_nettype none
module lzrp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire lzrp_pkg::in_item_t in_item,
	output logic                   req_valid,
	input  wire logic              req_ready,
	output lzrp_pkg::req_t         req
);
	import lzrp_pkg::*;

	phase_t      phase_q, ph;
	logic [31:0] produced_q, pr;
	logic [31:0] expected_q, ex;
	logic [7:0]  flags_q, fl;
	logic [2:0]  fcnt_q, fc;
	logic [31:0] cmd_q, cb;
	logic [6:0]  lit_q, li;
	logic [10:0] copy_q, cp;
	logic [17:0] dist_q, di;
	logic [7:0]  b;
	logic        taken, wr, rd, zero;
	logic [2:0]  slen;

	assign b = in_item.in_byte;
	assign in_ready = req_ready;

	// next-state decode of one byte
	always_comb begin
		ph = phase_q; pr = produced_q; ex = expected_q; fl = flags_q;
		fc = fcnt_q; cb = cmd_q; li = lit_q; cp = copy_q; di = dist_q;
		taken = 1'b1; wr = 1'b0; rd = 1'b0; zero = 1'b0;
		if (in_item.start_of_block) begin
			ph = PH_FLAGS; pr = '0; ex = '0; fl = '0; fc = '0; cb = '0;
			li = '0; cp = '0; di = '0;
		end
		slen = fl[7] ? 3'd4 : 3'd3;
		unique case (ph)
			PH_FLAGS: begin fl = b; ph = PH_SIG; end
			PH_SIG: begin
				slen = fl[7] ? 3'd4 : 3'd3;
				if (b != SigByte) ph = PH_ERR;
				else begin
					fc = slen;
					if (fl[0]) ph = PH_CSIZE;
					else begin ex = '0; ph = PH_DSIZE; end
				end
			end
			PH_CSIZE: begin
				fc = fc - 3'd1;
				if (fc == 3'd0) begin fc = slen; ex = '0; ph = PH_DSIZE; end
			end
			PH_DSIZE: begin
				ex = {ex[23:0], b};
				fc = fc - 3'd1;
				if (fc == 3'd0) ph = (ex == '0) ? PH_DONE : PH_CMD;
			end
			PH_CMD: begin
				cb = {24'd0, b};
				if (!b[7]) begin fc = 3'd1; ph = PH_ARGS; end
				else if (!b[6]) begin fc = 3'd2; ph = PH_ARGS; end
				else if (!b[5]) begin fc = 3'd3; ph = PH_ARGS; end
				else if (b < 8'hFC) begin
					li = {b[4:0], 2'b00} + 7'd4; cp = '0; ph = PH_LIT;
				end else begin
					li = {5'd0, b[1:0]}; cp = '0;
					ph = (b[1:0] != 2'd0) ? PH_LIT_STOP : PH_DONE;
				end
			end
			PH_ARGS: begin
				cb = {cb[23:0], b};
				fc = fc - 3'd1;
				if (fc == 3'd0) begin
					if (cb[31:24] != 8'd0) begin
						li = {5'd0, cb[25:24]};
						cp = {1'b0, cb[27:26], cb[7:0]} + 11'd5;
						di = {1'b0, cb[28], cb[23:8]} + 18'd1;
					end else if (cb[23]) begin
						li = {5'd0, cb[15:14]};
						cp = {5'd0, cb[21:16]} + 11'd4;
						di = {4'd0, cb[13:0]} + 18'd1;
					end else begin
						li = {5'd0, cb[9:8]};
						cp = {8'd0, cb[12:10]} + 11'd3;
						di = {8'd0, cb[14:13], cb[7:0]} + 18'd1;
					end
					ph = (li != 7'd0) ? PH_LIT : PH_COPY;
				end
			end
			PH_LIT, PH_LIT_STOP: begin
				wr = 1'b1;
				pr = pr + 32'd1;
				li = li - 7'd1;
				if (pr == ex) ph = PH_DONE;
				else if (li == 7'd0) begin
					if (ph == PH_LIT_STOP) ph = PH_DONE;
					else ph = (cp != '0) ? PH_COPY : PH_CMD;
				end
			end
			PH_COPY, PH_COPY_LAST: begin
				taken = 1'b0; wr = 1'b1; rd = 1'b1;
				zero = {14'd0, di} > pr;
				pr = pr + 32'd1;
				cp = cp - 11'd1;
				if (pr == ex) ph = PH_DONE;
				else if (cp == '0) ph = (ph == PH_COPY_LAST) ? PH_DONE : PH_CMD;
			end
			PH_DONE: ph = PH_DONE;
			PH_ERR: ph = PH_ERR;
			default: ph = PH_DONE;
		endcase
		// input ended
		if (taken && in_item.end_of_input && ph != PH_DONE && ph != PH_ERR) begin
			if (ph == PH_COPY || (ph == PH_LIT && cp != '0)) begin
				li = '0; ph = PH_COPY_LAST;
			end else ph = PH_DONE;
		end
	end

	assign req_valid = in_valid;
	assign req.wr = wr;
	assign req.rd = rd;
	assign req.zero = zero;
	assign req.ref_dist = di;
	assign req.lit = b;
	assign req.taken = taken;
	assign req.done = (ph == PH_DONE) || (ph == PH_ERR);
	assign req.status = (ph == PH_ERR);
	assign req.clr = in_item.start_of_block;

	// advance on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAGS; produced_q <= '0; expected_q <= '0; flags_q <= '0;
			fcnt_q <= '0; cmd_q <= '0; lit_q <= '0; copy_q <= '0; dist_q <= '0;
		end else if (in_valid && req_ready) begin
			phase_q <= ph; produced_q <= pr; expected_q <= ex; flags_q <= fl;
			fcnt_q <= fc; cmd_q <= cb; lit_q <= li; copy_q <= cp; dist_q <= di;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/lzrp_back.sv =====
// ----------------------------------------------------------------------------
// lzrp_back
// Window writer/reader with a three-entry output queue.
// ----------------------------------------------------------------------------
`default_nettype none
module lzrp_back #(
	parameter int WINDOW_DEPTH = 131072
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire lzrp_pkg::req_t     req,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output lzrp_pkg::out_item_t     out_item
);
	import lzrp_pkg::*;
	localparam int AW = $clog2(WINDOW_DEPTH);

	logic [AW-1:0] wp_q, wp, raddr, waddr;
	logic [7:0]    rdata, wdata;
	logic          fire, we;
	// stage 1: request waiting for read data
	logic          v_s1;
	req_t          r_s1;
	// forwarding of the byte written in the same cycle as the read
	logic          fwd_s1;
	logic [7:0]    fwd_data_s1;
	// output queue
	out_item_t     q_q [3];
	out_item_t     q_d [3];
	logic [1:0]    cnt_q;
	logic [1:0]    wr_idx;
	logic          push, pop;
	out_item_t     res;

	// stage 1 resolves its byte this cycle
	always_comb begin
		res.out_valid = r_s1.wr;
		res.byte_taken = r_s1.taken;
		res.block_done = r_s1.done;
		res.status = r_s1.status;
		if (!r_s1.wr || (r_s1.rd && r_s1.zero)) res.out_byte = 8'd0;
		else if (!r_s1.rd) res.out_byte = r_s1.lit;
		else if (fwd_s1) res.out_byte = fwd_data_s1;
		else res.out_byte = rdata;
	end

	// accept while the queue has room for everything in flight
	assign req_ready = ({1'b0, cnt_q} + {2'd0, v_s1}) < 3'd3;
	assign fire = req_valid && req_ready;
	assign push = v_s1;
	assign pop = out_valid && out_ready;
	assign wp = req.clr ? '0 : wp_q;
	assign raddr = wp - req.ref_dist[AW-1:0];
	// stage 1 writes its resolved byte at its own address
	assign we = v_s1 && r_s1.wr;
	assign wdata = res.out_byte;
	assign waddr = wp_q - AW'(1);

	lzrp_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; v_s1 <= 1'b0;
		end else begin
			v_s1 <= fire;
			if (fire) wp_q <= wp + (req.wr ? AW'(1) : AW'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			r_s1 <= req;
			fwd_s1 <= we && (waddr == raddr);
			fwd_data_s1 <= wdata;
		end
	end

	// output queue: hold results until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
	end

	// shift on pop, then append the new result behind the last one kept
	assign wr_idx = pop ? (cnt_q - 2'd1) : cnt_q;
	always_comb begin
		for (int i = 0; i < 3; i++) q_d[i] = q_q[i];
		if (pop) begin
			q_d[0] = q_q[1];
			q_d[1] = q_q[2];
		end
		if (push) q_d[wr_idx] = res;
	end
	always_ff @(posedge clk) begin
		q_q <= q_d;
	end
	assign out_valid = cnt_q != 2'd0;
	assign out_item = q_q[0];
endmodule
`default_nettype wire

// ===== rtl/core/lzrp_checker.sv =====
// ----------------------------------------------------------------------------
// lzrp_checker
// Port-level assertions for the decompressor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module lzrp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [11:0] out_data
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");
	// status implies done
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data[0] |-> out_data[1])
		else $error("status without block_done");
	// no byte emitted without valid flag
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data[11] |-> out_data[10:3] == 8'd0)
		else $error("byte without out_valid");
	// accepted item yields a result after stage 1 and the output queue
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("result missing");
endmodule

bind lz_refpack_decompressor_unit lzrp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire
